/* sv/unique_id_list_table_defines.svh */
// Assertion macros for the unique ID list table.
`ifndef UNIQUE_ID_LIST_TABLE_DEFINES_SVH
`define UNIQUE_ID_LIST_TABLE_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define UIDL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define UIDL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/uidl_pkg.sv */
package uidl_pkg;

  localparam int unsigned IdW   = 32;
  localparam int unsigned SlotW = 8;
  localparam int unsigned OutCntW = 5;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_READ   = 2'd3
  } kind_e;

  // Broadcast to every cell: lookup key plus commit controls.
  typedef struct packed {
    logic             ins_en;
    logic             rem_en;
    logic [IdW-1:0]   id;
    logic [SlotW-1:0] slot;
    logic [SlotW-1:0] used;
  } uidl_cmd_t;

  // Carried from cell to cell, one cell per cycle.
  typedef struct packed {
    logic           tok;
    logic           found;
    logic [IdW-1:0] rd;
  } uidl_sweep_t;

endpackage

/* sv/uidl_cell.sv */
module uidl_cell import uidl_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  uidl_cmd_t      cmd_i,
  input  uidl_sweep_t    sweep_i,
  input  logic [IdW-1:0] next_entry_i,
  output uidl_sweep_t    sweep_o,
  output logic [IdW-1:0] entry_o
);

  localparam logic [SlotW-1:0] IdxS = SlotW'(IDX);

  logic [IdW-1:0] entry_q, entry_d;
  logic           tok_q;
  logic           found_q;
  logic [IdW-1:0] rd_q;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins_en && (cmd_i.used == IdxS)) begin
      entry_d = cmd_i.id;
    end else if (cmd_i.rem_en && (IdxS >= cmd_i.slot)) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      tok_q   <= 1'b0;
    end else begin
      entry_q <= entry_d;
      tok_q   <= sweep_i.tok;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= sweep_i.found | (entry_q == cmd_i.id);
    rd_q    <= (cmd_i.slot == IdxS) ? entry_q : sweep_i.rd;
  end

  assign sweep_o = '{tok: tok_q, found: found_q, rd: rd_q};
  assign entry_o = entry_q;

endmodule

/* sv/unique_id_list_table.sv */
// Ordered list of up to DEPTH distinct nonzero IDs held in a row of cells. An item is
// taken when start_i is high and busy_o low; a lookup then walks the cell chain one cell
// per cycle, and busy_o stays high until its result is shown for one cycle on strobe_o.
// The result cannot be held off: it must be captured in the cycle strobe_o is high.
// entry_count_o carries the low five bits of the count after the item.
`include "unique_id_list_table_defines.svh"

module unique_id_list_table import uidl_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [1:0]           kind_i,
  input  logic [IdW-1:0]       node_id_i,
  input  logic [SlotW-1:0]     slot_i,
  output logic                 strobe_o,
  output logic                 ok_o,
  output logic [IdW-1:0]       id_out_o,
  output logic [OutCntW-1:0]   entry_count_o
);

  localparam int CntW = $clog2(DEPTH + 1);

  typedef enum logic {
    ST_IDLE,
    ST_SWEEP
  } state_e;

  state_e              state_q;
  logic                launch_q;
  logic                strobe_q;
  logic                ok_q;
  logic [IdW-1:0]      id_out_q;
  logic [CntW-1:0]     used_q, used_d;
  kind_e               kind_q;
  logic [IdW-1:0]      id_q;
  logic [SlotW-1:0]    slot_q;

  uidl_sweep_t         sweep_w [DEPTH+1];
  logic [IdW-1:0]      entry_w [DEPTH+1];
  logic [DEPTH-1:0]    tok_w;
  uidl_cmd_t           cmd_w;

  logic                done_w;
  logic                found_w;
  logic                slot_ok_w;
  logic                ok_w;
  logic                ins_w;
  logic                rem_w;
  logic [IdW-1:0]      rd_w;

  assign done_w    = (state_q == ST_SWEEP) && sweep_w[DEPTH].tok;
  assign found_w   = sweep_w[DEPTH].found && (id_q != '0);
  assign slot_ok_w = slot_q < SlotW'(used_q);

  always_comb begin
    ok_w   = 1'b0;
    ins_w  = 1'b0;
    rem_w  = 1'b0;
    rd_w   = '0;
    used_d = used_q;
    unique case (kind_q)
      KIND_INSERT: begin
        ok_w = (id_q != '0) && !found_w && (used_q < CntW'(DEPTH));
        ins_w = ok_w;
        if (ok_w) used_d = used_q + CntW'(1);
      end
      KIND_REMOVE: begin
        ok_w  = slot_ok_w;
        rem_w = ok_w;
        if (ok_w) used_d = used_q - CntW'(1);
      end
      KIND_QUERY: begin
        ok_w = found_w;
      end
      KIND_READ: begin
        ok_w = slot_ok_w;
        if (slot_ok_w) rd_w = sweep_w[DEPTH].rd;
      end
      default: ;
    endcase
  end

  assign cmd_w = '{
    ins_en: done_w && ins_w,
    rem_en: done_w && rem_w,
    id:     id_q,
    slot:   slot_q,
    used:   SlotW'(used_q)
  };

  assign sweep_w[0] = '{tok: launch_q, found: 1'b0, rd: '0};
  assign entry_w[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    uidl_cell #(
      .IDX(i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd_w),
      .sweep_i      (sweep_w[i]),
      .next_entry_i (entry_w[i+1]),
      .sweep_o      (sweep_w[i+1]),
      .entry_o      (entry_w[i])
    );
    assign tok_w[i] = sweep_w[i+1].tok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      launch_q <= 1'b0;
      strobe_q <= 1'b0;
      ok_q     <= 1'b0;
      id_out_q <= '0;
      used_q   <= '0;
    end else begin
      launch_q <= 1'b0;
      strobe_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            launch_q <= 1'b1;
            state_q  <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          if (done_w) begin
            strobe_q <= 1'b1;
            ok_q     <= ok_w;
            id_out_q <= rd_w;
            used_q   <= used_d;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == ST_IDLE)) begin
      kind_q <= kind_e'(kind_i);
      id_q   <= node_id_i;
      slot_q <= slot_i;
    end
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign strobe_o      = strobe_q;
  assign ok_o          = ok_q;
  assign id_out_o      = id_out_q;
  assign entry_count_o = OutCntW'(used_q);

  `UIDL_ASSERT(a_used_bound, used_q <= CntW'(DEPTH), "count exceeds depth")
  `UIDL_ASSERT(a_one_token, $onehot0({launch_q, tok_w}), "more than one sweep in flight")
  `UIDL_ASSERT(a_strobe_idle, !strobe_o || !busy_o, "result while busy")
  `UIDL_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o && launch_q,
                    "accepted item did not launch")

endmodule
